// ===== rtl/source_activity_table_lru_core_macros.svh =====
// Assertion macros shared by the source activity table RTL.
`ifndef SOURCE_ACTIVITY_TABLE_LRU_CORE_MACROS_SVH
`define SOURCE_ACTIVITY_TABLE_LRU_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define SAT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("source activity table: assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define SAT_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("source activity table: implication failed");

// Check that an antecedent implies a consequent in the next cycle.
`define SAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("source activity table: next-cycle check failed");

`else

`define SAT_ASSERT(label, clk, rstn, prop)
`define SAT_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define SAT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/sat_pkg.sv =====
package sat_pkg;

    localparam int SLOT_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FREE  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;
    localparam logic [1:0] OUT_READ  = 2'd3;

    localparam logic [31:0] STALE_LIMIT_RESET = 32'd10000;
    localparam logic [31:0] TIME_MAX          = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        is_read;
        logic [31:0] source_ip;
        logic [14:0] port_address;
        logic [15:0] frame_length;
        logic [31:0] now_ms;
        logic [4:0]  entry_index;
        logic        index_ok;
    } sat_cmd_t;

    typedef struct packed {
        logic    push;
        sat_cmd_t cmd;
    } sat_push_t;

    typedef struct packed {
        logic [14:0] port_address;
        logic [31:0] source_ip;
        logic [31:0] frame_count;
        logic [31:0] last_seen;
        logic [15:0] frame_length;
    } sat_entry_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [4:0]  slot_used;
        logic        entry_visible;
        logic [14:0] port_address;
        logic [31:0] entry_ip;
        logic [31:0] frame_count;
        logic [15:0] last_length;
        logic [31:0] age_ms;
    } sat_result_t;

endpackage

// ===== rtl/sat_ram.sv =====
module sat_ram #(
    parameter int WIDTH  = 127,
    parameter int DEPTH  = 24,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sat_front.sv =====
module sat_front #(
    parameter int TABLE_ENTRIES = 24
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [31:0]         s_source_ip,
    input  logic [7:0]          s_net_number,
    input  logic [7:0]          s_sub_universe,
    input  logic [15:0]         s_frame_length,
    input  logic [31:0]         s_now_ms,
    input  logic [4:0]          s_entry_index,
    input  logic                q_full,
    output sat_pkg::sat_push_t  push_o
);
    import sat_pkg::*;

    localparam logic [8:0] ENTRIES_9 = 9'(TABLE_ENTRIES);

    assign s_ready = !q_full;

    // Classify the request: build the port address, range-check the read slot.
    always_comb begin
        push_o.push              = s_valid && !q_full;
        push_o.cmd.is_read       = s_action;
        push_o.cmd.source_ip     = s_source_ip;
        push_o.cmd.port_address  = {s_net_number[6:0], s_sub_universe};
        push_o.cmd.frame_length  = s_frame_length;
        push_o.cmd.now_ms        = s_now_ms;
        push_o.cmd.entry_index   = s_entry_index;
        push_o.cmd.index_ok      = 9'(s_entry_index) < ENTRIES_9;
    end

endmodule

// ===== rtl/sat_queue.sv =====
`include "source_activity_table_lru_core_macros.svh"

module sat_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  sat_pkg::sat_push_t  push_i,
    output logic                q_full,
    output logic                q_valid,
    output sat_pkg::sat_cmd_t   q_cmd,
    input  logic                q_pop
);
    import sat_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    sat_cmd_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_full  = count_reg == FULL_CNT;
    assign q_valid = count_reg != '0;
    assign q_cmd   = slots_reg[rd_ptr_reg];
    assign do_push = push_i.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_i.cmd;
        end
    end

    `SAT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT)
    `SAT_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, q_full, !push_i.push)
    `SAT_ASSERT_NEXT(a_pop_drains, aclk, aresetn, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== rtl/sat_back.sv =====
`include "source_activity_table_lru_core_macros.svh"

module sat_back #(
    parameter int TABLE_ENTRIES = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 q_valid,
    input  sat_pkg::sat_cmd_t    q_cmd,
    output logic                 q_pop,
    output logic                 res_valid,
    output sat_pkg::sat_result_t res,
    input  logic                 m_ready
);
    import sat_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int ENTRY_W = $bits(sat_entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_RADDR = 3'd3;
    localparam logic [2:0] ST_RANS  = 3'd4;

    logic [2:0]               state_reg, state_next;
    sat_cmd_t                 cmd_reg, cmd_next;
    logic [IDX_W-1:0]         issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [31:0]              hit_count_reg, hit_count_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]         oldest_idx_reg, oldest_idx_next;
    logic [31:0]              oldest_t_reg, oldest_t_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              stale_limit_reg;
    logic                     res_valid_reg, res_valid_next;
    sat_result_t              res_reg, res_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
    sat_entry_t               rd_entry, new_entry;

    logic                     res_free;
    logic                     chk_used, match;
    logic [SW-1:0]            entry_ext, slot_ext;
    logic [IDX_W-1:0]         read_idx, wr_slot;
    logic                     read_used;
    logic [31:0]              read_age;
    logic                     evict_at_end;

    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_entry  = sat_entry_t'(ram_rdata);
    assign res_free  = !res_valid_reg || m_ready;
    assign chk_used  = valid_reg[chk_idx_reg];
    assign match     = chk_used && rd_entry.port_address == cmd_reg.port_address
                       && rd_entry.source_ip == cmd_reg.source_ip;
    assign entry_ext = SW'(cmd_reg.entry_index);
    assign read_idx  = entry_ext[IDX_W-1:0];
    assign read_used = cmd_reg.index_ok ? valid_reg[read_idx] : 1'b0;
    assign read_age  = cmd_reg.now_ms - rd_entry.last_seen;
    assign wr_slot   = hit_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : oldest_idx_reg);
    assign slot_ext  = SW'(wr_slot);
    assign evict_at_end = state_reg == ST_SCAN && chk_vld_reg && chk_idx_reg == LAST_IDX
                          && !match && !free_found_reg && chk_used;

    always_comb begin
        new_entry.port_address = cmd_reg.port_address;
        new_entry.source_ip    = cmd_reg.source_ip;
        new_entry.frame_count  = hit_reg ? hit_count_reg + 32'd1 : 32'd1;
        new_entry.last_seen    = cmd_reg.now_ms;
        new_entry.frame_length = cmd_reg.frame_length;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_idx_next  = issue_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oldest_idx_next = oldest_idx_reg;
        oldest_t_next   = oldest_t_reg;
        valid_next      = valid_reg;
        res_valid_next  = res_valid_reg && !m_ready;
        res_next        = res_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_slot;
        ram_wdata       = ENTRY_W'(new_entry);
        ram_raddr       = issue_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    cmd_next        = q_cmd;
                    issue_idx_next  = '0;
                    chk_vld_next    = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    oldest_idx_next = '0;
                    oldest_t_next   = TIME_MAX;
                    state_next      = q_cmd.is_read ? ST_RADDR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one slot read per cycle; check the slot read the cycle before.
                chk_vld_next   = 1'b1;
                chk_idx_next   = issue_idx_reg;
                issue_idx_next = (issue_idx_reg == LAST_IDX) ? issue_idx_reg
                                                             : issue_idx_reg + 1'b1;
                if (chk_vld_reg) begin
                    if (match) begin
                        hit_next       = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_count_next = rd_entry.frame_count;
                        state_next     = ST_WRITE;
                    end else begin
                        if (!chk_used) begin
                            if (!free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = chk_idx_reg;
                            end
                        end else if (rd_entry.last_seen < oldest_t_reg) begin
                            oldest_t_next   = rd_entry.last_seen;
                            oldest_idx_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST_IDX) begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                if (res_free) begin
                    ram_we                 = 1'b1;
                    valid_next[wr_slot]    = 1'b1;
                    res_valid_next         = 1'b1;
                    res_next.outcome       = hit_reg ? OUT_HIT
                                             : (free_found_reg ? OUT_FREE : OUT_EVICT);
                    res_next.slot_used     = slot_ext[SLOT_W-1:0];
                    res_next.entry_visible = 1'b0;
                    res_next.port_address  = new_entry.port_address;
                    res_next.entry_ip      = new_entry.source_ip;
                    res_next.frame_count   = new_entry.frame_count;
                    res_next.last_length   = new_entry.frame_length;
                    res_next.age_ms        = '0;
                    state_next             = ST_IDLE;
                end
            end
            ST_RADDR: begin
                ram_raddr  = read_idx;
                state_next = ST_RANS;
            end
            ST_RANS: begin
                // Keep the address so the read data holds while stalled.
                ram_raddr = read_idx;
                if (res_free) begin
                    res_valid_next         = 1'b1;
                    res_next.outcome       = OUT_READ;
                    res_next.slot_used     = cmd_reg.entry_index;
                    res_next.entry_visible = read_used && read_age <= stale_limit_reg;
                    res_next.port_address  = read_used ? rd_entry.port_address : '0;
                    res_next.entry_ip      = read_used ? rd_entry.source_ip : '0;
                    res_next.frame_count   = read_used ? rd_entry.frame_count : '0;
                    res_next.last_length   = read_used ? rd_entry.frame_length : '0;
                    res_next.age_ms        = read_used ? read_age : '0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            chk_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_reg       <= '0;
            stale_limit_reg <= STALE_LIMIT_RESET;
            res_valid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en) begin
                stale_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        free_idx_reg   <= free_idx_next;
        oldest_idx_reg <= oldest_idx_next;
        oldest_t_reg   <= oldest_t_next;
        res_reg        <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `SAT_ASSERT_IMPLIES(a_record_not_visible, aclk, aresetn, res_valid_reg && res_reg.outcome != OUT_READ, !res_reg.entry_visible && res_reg.age_ms == '0)
    `SAT_ASSERT_IMPLIES(a_pop_only_idle, aclk, aresetn, q_pop, state_reg == ST_IDLE)
    `SAT_ASSERT_IMPLIES(a_evict_only_full, aclk, aresetn, evict_at_end, &valid_reg)

endmodule

// ===== rtl/source_activity_table_lru_core.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  action, source_ip, net_number, sub_universe,
//                                         frame_length, now_ms, entry_index
// m_        out        m_valid / m_ready  outcome, slot_used, entry_visible, port_address,
//                                         entry_ip, frame_count, last_length, age_ms
// cfg_      in         cfg_wr_en          cfg_wr_data (stale limit in ms)
//
// A record scans the table, stopping early on a hit: the slot scan reads the table memory
// one slot per cycle through its single read port.
// A read steps through queue pop, memory address and answer.
// Reset clears the used bits at once; there is no clearing pass.
// A two-entry request queue takes requests while the back end scans and drops s_ready
// only when full; the back end holds its final step while a result waits on m_ready.
module source_activity_table_lru_core #(
    parameter int TABLE_ENTRIES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_source_ip,
    input  logic [7:0]  s_net_number,
    input  logic [7:0]  s_sub_universe,
    input  logic [15:0] s_frame_length,
    input  logic [31:0] s_now_ms,
    input  logic [4:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [4:0]  m_slot_used,
    output logic        m_entry_visible,
    output logic [14:0] m_port_address,
    output logic [31:0] m_entry_ip,
    output logic [31:0] m_frame_count,
    output logic [15:0] m_last_length,
    output logic [31:0] m_age_ms
);
    import sat_pkg::*;

    sat_push_t   push;
    logic        q_full;
    logic        q_valid;
    sat_cmd_t    q_cmd;
    logic        q_pop;
    sat_result_t res;

    sat_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_source_ip   (s_source_ip),
        .s_net_number  (s_net_number),
        .s_sub_universe(s_sub_universe),
        .s_frame_length(s_frame_length),
        .s_now_ms      (s_now_ms),
        .s_entry_index (s_entry_index),
        .q_full        (q_full),
        .push_o        (push)
    );

    sat_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push_i (push),
        .q_full (q_full),
        .q_valid(q_valid),
        .q_cmd  (q_cmd),
        .q_pop  (q_pop)
    );

    sat_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .res_valid  (m_valid),
        .res        (res),
        .m_ready    (m_ready)
    );

    assign m_outcome       = res.outcome;
    assign m_slot_used     = res.slot_used;
    assign m_entry_visible = res.entry_visible;
    assign m_port_address  = res.port_address;
    assign m_entry_ip      = res.entry_ip;
    assign m_frame_count   = res.frame_count;
    assign m_last_length   = res.last_length;
    assign m_age_ms        = res.age_ms;

endmodule
